// File: rtl/core/sbtp_pkg.sv
package sbtp_pkg;

    // Alphabet size: codes at or above this value carry no character.
    localparam logic [5:0] ALPHA_LEN   = 6'd62;
    localparam logic [5:0] DOLLAR_CODE = 6'd61;
    localparam logic [5:0] TERM_CODE   = 6'd0;

    localparam logic MODE_ENCODE = 1'b0;
    localparam logic MODE_DECODE = 1'b1;

    // Result queue between the front and back parts.
    localparam int QDEPTH = 2;
    localparam int QAW    = $clog2(QDEPTH);

    // Up to three results caused by one input item.
    typedef struct packed {
        logic [1:0]      cnt;
        logic [2:0][7:0] bytes;
        logic [2:0]      dbg;
        logic            fin;
    } res_bundle_t;

    typedef struct packed {
        logic        push;
        res_bundle_t bundle;
    } q_push_t;

    typedef struct packed {
        logic        valid;
        res_bundle_t bundle;
    } q_head_t;

    typedef struct packed {
        logic       emit;
        logic [7:0] ch;
        logic       dbg;
        logic       done;
        logic       dseen;
    } take_t;

    // Character to {valid, code}; lower-case letters fold to upper case.
    function automatic logic [6:0] code_of(input logic [7:0] c_in);
        logic [7:0] c;
        logic [6:0] r;
        c = c_in;
        if (c >= 8'd97 && c <= 8'd122)
        begin
            c = c - 8'd32;
        end
        r = 7'h00;
        if (c == 8'd0)
        begin
            r = {1'b1, TERM_CODE};
        end
        else if (c >= 8'd65 && c <= 8'd90)
        begin
            r = {1'b1, 6'(c - 8'd64)};
        end
        else if (c >= 8'd48 && c <= 8'd57)
        begin
            r = {1'b1, 6'(c - 8'd21)};
        end
        else
        begin
            case (c)
                8'h20:   r = {1'b1, 6'd37};
                8'h2E:   r = {1'b1, 6'd38};
                8'h2C:   r = {1'b1, 6'd39};
                8'h3C:   r = {1'b1, 6'd40};
                8'h3E:   r = {1'b1, 6'd41};
                8'h2F:   r = {1'b1, 6'd42};
                8'h3F:   r = {1'b1, 6'd43};
                8'h3B:   r = {1'b1, 6'd44};
                8'h3A:   r = {1'b1, 6'd45};
                8'h7C:   r = {1'b1, 6'd46};
                8'h22:   r = {1'b1, 6'd47};
                8'h21:   r = {1'b1, 6'd48};
                8'h40:   r = {1'b1, 6'd49};
                8'h23:   r = {1'b1, 6'd50};
                8'h25:   r = {1'b1, 6'd51};
                8'h26:   r = {1'b1, 6'd52};
                8'h2A:   r = {1'b1, 6'd53};
                8'h28:   r = {1'b1, 6'd54};
                8'h29:   r = {1'b1, 6'd55};
                8'h2D:   r = {1'b1, 6'd56};
                8'h5F:   r = {1'b1, 6'd57};
                8'h3D:   r = {1'b1, 6'd58};
                8'h2B:   r = {1'b1, 6'd59};
                8'h27:   r = {1'b1, 6'd60};
                8'h24:   r = {1'b1, DOLLAR_CODE};
                default: r = 7'h00;
            endcase
        end
        return r;
    endfunction

    // Code to character; codes outside the alphabet give zero.
    function automatic logic [7:0] char_of(input logic [5:0] code);
        logic [7:0] r;
        r = 8'h00;
        if (code >= 6'd1 && code <= 6'd26)
        begin
            r = {2'b00, code} + 8'd64;
        end
        else if (code >= 6'd27 && code <= 6'd36)
        begin
            r = {2'b00, code} + 8'd21;
        end
        else
        begin
            case (code)
                6'd37:   r = 8'h20;
                6'd38:   r = 8'h2E;
                6'd39:   r = 8'h2C;
                6'd40:   r = 8'h3C;
                6'd41:   r = 8'h3E;
                6'd42:   r = 8'h2F;
                6'd43:   r = 8'h3F;
                6'd44:   r = 8'h3B;
                6'd45:   r = 8'h3A;
                6'd46:   r = 8'h7C;
                6'd47:   r = 8'h22;
                6'd48:   r = 8'h21;
                6'd49:   r = 8'h40;
                6'd50:   r = 8'h23;
                6'd51:   r = 8'h25;
                6'd52:   r = 8'h26;
                6'd53:   r = 8'h2A;
                6'd54:   r = 8'h28;
                6'd55:   r = 8'h29;
                6'd56:   r = 8'h2D;
                6'd57:   r = 8'h5F;
                6'd58:   r = 8'h3D;
                6'd59:   r = 8'h2B;
                6'd60:   r = 8'h27;
                6'd61:   r = 8'h24;
                default: r = 8'h00;
            endcase
        end
        return r;
    endfunction

    // One decoded code: terminator, swallowed dollar, skipped code or a character.
    function automatic take_t take_code(input logic [5:0] code, input logic done,
                                        input logic dseen);
        take_t t;
        t.emit  = 1'b0;
        t.ch    = 8'h00;
        t.dbg   = 1'b0;
        t.done  = done;
        t.dseen = dseen;
        if (!done && code < ALPHA_LEN)
        begin
            if (code == TERM_CODE)
            begin
                t.emit = 1'b1;
                t.done = 1'b1;
            end
            else if (code == DOLLAR_CODE && !dseen)
            begin
                t.dseen = 1'b1;
            end
            else
            begin
                t.emit = 1'b1;
                t.ch   = char_of(code);
                t.dbg  = dseen;
            end
        end
        return t;
    endfunction

endpackage

// File: rtl/core/sixbit_text_pack_codec.sv
// The first result of an item is written into the result queue and then into the registered output stage.
// Throughput: one item per cycle while each item gives at most one result and the queue is not full; the output
// port drives one result per cycle while result_stall is low, so a multi-result item holds it for longer.
// A two-entry result queue between the classifying front part and the output part lets each stall on its own.
// Reset (rst_n low, asynchronous) empties the queue and output, selects encode mode and
// clears the bit phase, held bits, debug flag and message-done flag.
module sixbit_text_pack_codec (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       mode_we,
    input  logic       mode_wdata,
    input  logic       item_valid,
    output logic       item_stall,
    input  logic [7:0] data_byte,
    input  logic       end_of_message,
    output logic       result_valid,
    input  logic       result_stall,
    output logic [7:0] out_byte,
    output logic       is_debug,
    output logic       final_result
);
    import sbtp_pkg::*;

    // The front part holds the mode register and the codec state.  On each
    // accepted transaction it works out every result the item causes
    // combinationally, in order, and pushes them into the queue as a single bundle.
    // Items that cause no result (a dropped character, a skipped code or a
    // swallowed dollar) update the state and push nothing.
    q_push_t q_push;
    q_head_t q_head;
    logic    q_full;
    logic    q_pop;
    logic    mode;

    sbtp_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .mode_we        (mode_we),
        .mode_wdata     (mode_wdata),
        .item_valid     (item_valid),
        .item_stall     (item_stall),
        .data_byte      (data_byte),
        .end_of_message (end_of_message),
        .q_full         (q_full),
        .q_push         (q_push),
        .mode           (mode)
    );

    // The queue decouples the two sides, so until it is full the front keeps taking items
    // while the output side is stalled or still emitting a multi-result bundle.
    sbtp_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .q_push (q_push),
        .q_full (q_full),
        .q_head (q_head),
        .q_pop  (q_pop)
    );

    // The back part walks through the head bundle one result per transaction
    // into a registered output stage, marking the message's last result.
    sbtp_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_head       (q_head),
        .q_pop        (q_pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .out_byte     (out_byte),
        .is_debug     (is_debug),
        .final_result (final_result)
    );

    // The last item of a message always produces results, so a bundle is queued.
    a_eom_pushes: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && !item_stall && end_of_message |=> q_head.valid)
        else $error("end of message left the result queue empty");

    // Encoded bytes never carry the debug mark.
    a_enc_no_debug: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (mode == MODE_ENCODE) |-> !is_debug)
        else $error("debug mark on an encoded byte");

    // A decoded terminator is never marked as debug.
    a_term_no_debug: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (mode == MODE_DECODE) && (out_byte == 8'h00) |-> !is_debug)
        else $error("debug mark on a terminator");

    // A bundle is never pushed into a full queue.
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_push.push |-> !q_full)
        else $error("push into a full result queue");

endmodule

// File: rtl/core/sbtp_front.sv
module sbtp_front (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             mode_we,
    input  logic             mode_wdata,
    input  logic             item_valid,
    output logic             item_stall,
    input  logic [7:0]       data_byte,
    input  logic             end_of_message,
    input  logic             q_full,
    output sbtp_pkg::q_push_t q_push,
    output logic             mode
);
    import sbtp_pkg::*;

    logic       mode_reg;
    logic [1:0] phase_reg, phase_next;
    logic [7:0] partial_reg, partial_next;
    logic       dbg_reg, dbg_next;
    logic       done_reg, done_next;
    logic       accept;

    res_bundle_t res;
    logic [1:0]  n;
    logic [6:0]  cv;
    logic [5:0]  v;
    logic [5:0]  code_a, code_b;
    logic        use_b;
    take_t       ta, tb;

    assign item_stall = q_full;
    assign accept     = item_valid && !q_full;
    assign mode       = mode_reg;

    always_comb
    begin
        res          = '0;
        n            = 2'd0;
        phase_next   = phase_reg;
        partial_next = partial_reg;
        dbg_next     = dbg_reg;
        done_next    = done_reg;
        cv           = code_of(data_byte);
        v            = cv[5:0];
        code_a       = data_byte[7:2];
        code_b       = data_byte[5:0];
        use_b        = 1'b0;
        ta           = '0;
        tb           = '0;

        if (mode_reg == MODE_ENCODE)
        begin
            if (cv[6])
            begin
                case (phase_reg)
                    2'd0:
                    begin
                        partial_next = {v, 2'b00};
                        phase_next   = 2'd1;
                    end
                    2'd1:
                    begin
                        res.bytes[n] = {partial_reg[7:2], v[5:4]};
                        n            = n + 2'd1;
                        partial_next = {v[3:0], 4'b0000};
                        phase_next   = 2'd2;
                    end
                    2'd2:
                    begin
                        res.bytes[n] = {partial_reg[7:4], v[5:2]};
                        n            = n + 2'd1;
                        partial_next = {v[1:0], 6'b000000};
                        phase_next   = 2'd3;
                    end
                    default:
                    begin
                        res.bytes[n] = {partial_reg[7:6], v};
                        n            = n + 2'd1;
                        partial_next = 8'h00;
                        phase_next   = 2'd0;
                    end
                endcase
            end
            if (end_of_message)
            begin
                res.bytes[n] = (phase_next != 2'd0) ? partial_next : 8'h00;
                n            = n + 2'd1;
                res.bytes[n] = 8'h00;
                n            = n + 2'd1;
            end
        end
        else
        begin
            case (phase_reg)
                2'd1:
                begin
                    code_a       = {partial_reg[1:0], data_byte[7:4]};
                    partial_next = {4'b0000, data_byte[3:0]};
                    phase_next   = 2'd2;
                end
                2'd2:
                begin
                    code_a       = {partial_reg[3:0], data_byte[7:6]};
                    use_b        = 1'b1;
                    partial_next = 8'h00;
                    phase_next   = 2'd0;
                end
                default:
                begin
                    code_a       = data_byte[7:2];
                    partial_next = {6'b000000, data_byte[1:0]};
                    phase_next   = 2'd1;
                end
            endcase
            ta = take_code(code_a, done_reg, dbg_reg);
            if (ta.emit)
            begin
                res.bytes[n] = ta.ch;
                res.dbg[n]   = ta.dbg;
                n            = n + 2'd1;
            end
            done_next = ta.done;
            dbg_next  = ta.dseen;
            if (use_b)
            begin
                tb = take_code(code_b, ta.done, ta.dseen);
                if (tb.emit)
                begin
                    res.bytes[n] = tb.ch;
                    res.dbg[n]   = tb.dbg;
                    n            = n + 2'd1;
                end
                done_next = tb.done;
                dbg_next  = tb.dseen;
            end
            if (end_of_message && (!done_next || n == 2'd0))
            begin
                res.bytes[n] = 8'h00;
                res.dbg[n]   = 1'b0;
                n            = n + 2'd1;
            end
        end

        res.cnt = n;
        res.fin = end_of_message;

        if (end_of_message)
        begin
            phase_next   = 2'd0;
            partial_next = 8'h00;
            dbg_next     = 1'b0;
            done_next    = 1'b0;
        end
    end

    assign q_push.push   = accept && (n != 2'd0);
    assign q_push.bundle = res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= MODE_ENCODE;
            phase_reg   <= 2'd0;
            partial_reg <= 8'h00;
            dbg_reg     <= 1'b0;
            done_reg    <= 1'b0;
        end
        else if (mode_we)
        begin
            mode_reg    <= mode_wdata;
            phase_reg   <= 2'd0;
            partial_reg <= 8'h00;
            dbg_reg     <= 1'b0;
            done_reg    <= 1'b0;
        end
        else if (accept)
        begin
            phase_reg   <= phase_next;
            partial_reg <= partial_next;
            dbg_reg     <= dbg_next;
            done_reg    <= done_next;
        end
    end

endmodule

// File: rtl/core/sbtp_queue.sv
module sbtp_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  sbtp_pkg::q_push_t q_push,
    output logic              q_full,
    output sbtp_pkg::q_head_t q_head,
    input  logic              q_pop
);
    import sbtp_pkg::*;

    res_bundle_t      mem_reg [QDEPTH];
    logic [QAW-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [QAW:0]     cnt_reg, cnt_next;
    logic             do_push, do_pop;

    assign q_full        = (cnt_reg == (QAW+1)'(QDEPTH));
    assign do_push       = q_push.push && !q_full;
    assign do_pop        = q_pop && (cnt_reg != '0);
    assign q_head.valid  = (cnt_reg != '0);
    assign q_head.bundle = mem_reg[rd_ptr_reg];

    always_comb
    begin
        cnt_next = cnt_reg;
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= q_push.bundle;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            cnt_reg <= cnt_next;
        end
    end

endmodule

// File: rtl/core/sbtp_back.sv
module sbtp_back (
    input  logic              clk,
    input  logic              rst_n,
    input  sbtp_pkg::q_head_t q_head,
    output logic              q_pop,
    output logic              result_valid,
    input  logic              result_stall,
    output logic [7:0]        out_byte,
    output logic              is_debug,
    output logic              final_result
);
    import sbtp_pkg::*;

    logic [1:0] sel_reg;
    logic       valid_reg;
    logic [7:0] byte_reg;
    logic       dbg_reg;
    logic       fin_reg;
    logic       load;
    logic       last_sel;

    assign load     = q_head.valid && (!valid_reg || !result_stall);
    assign last_sel = (sel_reg == q_head.bundle.cnt - 2'd1);
    assign q_pop    = load && last_sel;

    assign result_valid = valid_reg;
    assign out_byte     = byte_reg;
    assign is_debug     = dbg_reg;
    assign final_result = fin_reg;

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            byte_reg <= q_head.bundle.bytes[sel_reg];
            dbg_reg  <= q_head.bundle.dbg[sel_reg];
            fin_reg  <= q_head.bundle.fin && last_sel;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            sel_reg   <= 2'd0;
        end
        else
        begin
            if (load)
            begin
                valid_reg <= 1'b1;
                sel_reg   <= last_sel ? 2'd0 : sel_reg + 2'd1;
            end
            else if (!result_stall)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

endmodule
